// ===== hdl/fdef_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry filter package
// Shared types, constants and character helpers for the entry filter.
// ----------------------------------------------------------------------------
package fdef_pkg;

  localparam int ENTRY_BYTES = 32;
  localparam int POS_W       = $clog2(ENTRY_BYTES);
  localparam int NAME_BYTES  = 8;
  localparam int EXT_BYTES   = 3;
  localparam int COUNT_W     = 10;
  localparam int NAME_LEN_W  = 4;
  localparam int EXT_LEN_W   = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] BYTE_END_MARK  = 8'h00;
  localparam logic [7:0] BYTE_DELETED   = 8'hE5;
  localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
  localparam logic [7:0] ATTR_SKIP_MASK = 8'h18;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  localparam int ATTR_POS = 11;

  localparam logic [1:0] REG_WANTED_EXT     = 2'd0;
  localparam logic [1:0] REG_WANTED_EXT_LEN = 2'd1;
  localparam logic [1:0] REG_MAX_FILES      = 2'd2;

  localparam logic [9:0] MAX_FILES_RESET = 10'd64;

  localparam logic STATUS_MATCH = 1'b0;
  localparam logic STATUS_END   = 1'b1;

  typedef struct packed {
    logic                       is_end;
    logic [COUNT_W-1:0]         index;
    logic [8*NAME_BYTES-1:0]    name_raw;
    logic [8*EXT_BYTES-1:0]     ext_raw;
    logic [31:0]                size;
    logic [31:0]                cluster;
  } entry_rec_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== hdl/fat_directory_entry_filter.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry filter
// Scans a FAT directory byte stream and reports matching files and the end.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, op, dir_byte) takes one item per
// cycle while in_ready is high: a directory byte, or with op high the start
// of a new scan. Bytes are grouped into 32-byte entries. When the last byte
// of an entry is accepted, the entry is classified and a match or end record
// enters a two-entry queue. The output channel (out_valid, out_ready and the
// result fields) presents each result from the output register. Throughput is
// one input item per cycle. At most one result is produced per 32 bytes, so
// the queue and output register absorb a stall of the receiver; in_ready
// drops only while the queue is full.
// The APB port sets the wanted extension, its length and the match limit,
// and should be written while no scan is in progress.
// Reset empties the queue and output register, clears the byte position,
// match count and finished flag, and loads the register reset values.
// ----------------------------------------------------------------------------
module fat_directory_entry_filter
  import fdef_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [7:0]               dir_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     status,
  output logic [COUNT_W-1:0]       file_index,
  output logic [8*NAME_BYTES-1:0]  name_text,
  output logic [NAME_LEN_W-1:0]    name_length,
  output logic [8*EXT_BYTES-1:0]   ext_text,
  output logic [EXT_LEN_W-1:0]     ext_length,
  output logic [31:0]              file_size,
  output logic [31:0]              first_cluster,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [23:0]        wanted_extension;
  logic [1:0]         wanted_extension_length;
  logic [COUNT_W-1:0] max_files;
  logic               cfg_write;

  logic               push_valid;
  logic               push_ready;
  entry_rec_t         push_rec;
  logic               pop_valid;
  logic               pop_ready;
  entry_rec_t         pop_rec;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_extension        <= '0;
      wanted_extension_length <= '0;
      max_files               <= MAX_FILES_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_WANTED_EXT:     wanted_extension        <= pwdata[23:0];
        REG_WANTED_EXT_LEN: wanted_extension_length <= pwdata[1:0];
        REG_MAX_FILES:      max_files               <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WANTED_EXT:     prdata = {8'h00, wanted_extension};
      REG_WANTED_EXT_LEN: prdata = {30'h0, wanted_extension_length};
      REG_MAX_FILES:      prdata = {{(32 - COUNT_W){1'b0}}, max_files};
      default:            prdata = '0;
    endcase
  end

  fdef_front u_front (
    .clk                     (clk),
    .rst                     (rst),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .op                      (op),
    .dir_byte                (dir_byte),
    .wanted_extension        (wanted_extension),
    .wanted_extension_length (wanted_extension_length),
    .max_files               (max_files),
    .push_ready              (push_ready),
    .push_valid              (push_valid),
    .push_rec                (push_rec)
  );

  fdef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  fdef_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_rec       (pop_rec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .file_index    (file_index),
    .name_text     (name_text),
    .name_length   (name_length),
    .ext_text      (ext_text),
    .ext_length    (ext_length),
    .file_size     (file_size),
    .first_cluster (first_cluster)
  );

endmodule

// ===== hdl/fdef_front.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry filter front end
// Collects directory bytes into an entry, classifies the completed entry and
// pushes end and match records into the queue.
// ----------------------------------------------------------------------------
module fdef_front
  import fdef_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [7:0]          dir_byte,
  input  logic [23:0]         wanted_extension,
  input  logic [1:0]          wanted_extension_length,
  input  logic [COUNT_W-1:0]  max_files,
  input  logic                push_ready,
  output logic                push_valid,
  output entry_rec_t          push_rec
);

  logic [7:0]         entry [0:ENTRY_BYTES-2];
  logic [POS_W-1:0]   byte_position;
  logic [COUNT_W-1:0] match_count;
  logic               scan_finished;

  logic               accept;
  logic               take_byte;
  logic               last_byte;
  logic               limit_hit;
  logic               is_end;
  logic               skip;
  logic               ext_ok;
  logic               is_match;
  logic [COUNT_W-1:0] count_inc;

  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;
  assign take_byte = accept && !op && !scan_finished;
  assign last_byte = (byte_position == POS_W'(ENTRY_BYTES - 1));

  always_comb begin
    logic [7:0] eb;
    logic [7:0] wc;
    ext_ok = 1'b1;
    for (int i = 0; i < EXT_BYTES; i++) begin
      eb = entry[NAME_BYTES + i];
      wc = wanted_extension[8*i +: 8];
      if (EXT_LEN_W'(i) < wanted_extension_length) begin
        if (to_upper(eb) != to_upper(wc)) begin
          ext_ok = 1'b0;
        end
      end else if (eb != CHAR_SPACE) begin
        ext_ok = 1'b0;
      end
    end
  end

  assign limit_hit = (match_count >= max_files);
  assign is_end    = (entry[0] == BYTE_END_MARK);
  assign skip      = (entry[0] == BYTE_DELETED) || (entry[ATTR_POS] == ATTR_LONG_NAME) ||
                     ((entry[ATTR_POS] & ATTR_SKIP_MASK) != 8'h00) || !ext_ok;
  assign is_match  = !limit_hit && !is_end && !skip;
  assign count_inc = match_count + COUNT_W'(1);

  assign push_valid = take_byte && last_byte && !limit_hit && (is_end || !skip);

  always_comb begin
    push_rec.is_end  = is_end;
    push_rec.index   = match_count;
    for (int i = 0; i < NAME_BYTES; i++) begin
      push_rec.name_raw[8*i +: 8] = entry[i];
    end
    for (int i = 0; i < EXT_BYTES; i++) begin
      push_rec.ext_raw[8*i +: 8] = entry[NAME_BYTES + i];
    end
    push_rec.size    = {dir_byte, entry[30], entry[29], entry[28]};
    push_rec.cluster = {entry[21], entry[20], entry[27], entry[26]};
  end

  always_ff @(posedge clk) begin
    if (take_byte && !last_byte) begin
      entry[byte_position] <= dir_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      match_count   <= '0;
      scan_finished <= 1'b0;
    end else if (accept && op) begin
      byte_position <= '0;
      match_count   <= '0;
      scan_finished <= 1'b0;
    end else if (take_byte) begin
      if (!last_byte) begin
        byte_position <= byte_position + POS_W'(1);
      end else begin
        byte_position <= '0;
        if (limit_hit || is_end) begin
          scan_finished <= 1'b1;
        end else if (is_match) begin
          match_count <= count_inc;
          if (count_inc >= max_files) begin
            scan_finished <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/fdef_queue.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry filter queue
// Short first-in first-out queue of entry records between front and back.
// ----------------------------------------------------------------------------
module fdef_queue
  import fdef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  entry_rec_t push_rec,
  output logic       pop_valid,
  input  logic       pop_ready,
  output entry_rec_t pop_rec
);

  entry_rec_t           slots [0:QUEUE_DEPTH-1];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_rec    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

// ===== hdl/fdef_back.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry filter back end
// Trims and lower-cases a match record's name and extension, zeroes an end
// record's file fields and holds the result in the output register until taken.
// ----------------------------------------------------------------------------
module fdef_back
  import fdef_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  entry_rec_t               pop_rec,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     status,
  output logic [COUNT_W-1:0]       file_index,
  output logic [8*NAME_BYTES-1:0]  name_text,
  output logic [NAME_LEN_W-1:0]    name_length,
  output logic [8*EXT_BYTES-1:0]   ext_text,
  output logic [EXT_LEN_W-1:0]     ext_length,
  output logic [31:0]              file_size,
  output logic [31:0]              first_cluster
);

  logic [NAME_LEN_W-1:0]   nm;
  logic [EXT_LEN_W-1:0]    ex;
  logic [8*NAME_BYTES-1:0] name_fmt;
  logic [8*EXT_BYTES-1:0]  ext_fmt;
  logic                    load;

  always_comb begin
    nm = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (pop_rec.name_raw[8*i +: 8] != CHAR_SPACE) begin
        nm = NAME_LEN_W'(i + 1);
      end
    end
    for (int i = 0; i < NAME_BYTES; i++) begin
      name_fmt[8*i +: 8] = (NAME_LEN_W'(i) < nm) ? to_lower(pop_rec.name_raw[8*i +: 8]) :
                                                   8'h00;
    end
    ex = '0;
    for (int i = 0; i < EXT_BYTES; i++) begin
      if (pop_rec.ext_raw[8*i +: 8] != CHAR_SPACE) begin
        ex = EXT_LEN_W'(i + 1);
      end
    end
    for (int i = 0; i < EXT_BYTES; i++) begin
      ext_fmt[8*i +: 8] = (EXT_LEN_W'(i) < ex) ? to_lower(pop_rec.ext_raw[8*i +: 8]) : 8'h00;
    end
  end

  assign pop_ready = !out_valid || out_ready;
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      file_index <= pop_rec.index;
      if (pop_rec.is_end) begin
        status        <= STATUS_END;
        name_text     <= '0;
        name_length   <= '0;
        ext_text      <= '0;
        ext_length    <= '0;
        file_size     <= '0;
        first_cluster <= '0;
      end else begin
        status        <= STATUS_MATCH;
        name_text     <= name_fmt;
        name_length   <= nm;
        ext_text      <= ext_fmt;
        ext_length    <= ex;
        file_size     <= pop_rec.size;
        first_cluster <= pop_rec.cluster;
      end
    end
  end

endmodule

// ===== hdl/fdef_checker.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry filter checker
// Port-level assertions on the entry filter, attached to the top level.
// ----------------------------------------------------------------------------
module fdef_checker
  import fdef_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     status,
  input  logic [COUNT_W-1:0]       file_index,
  input  logic [8*NAME_BYTES-1:0]  name_text,
  input  logic [NAME_LEN_W-1:0]    name_length,
  input  logic [8*EXT_BYTES-1:0]   ext_text,
  input  logic [EXT_LEN_W-1:0]     ext_length,
  input  logic [31:0]              file_size,
  input  logic [31:0]              first_cluster,
  input  logic                     pready
);

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(file_index) && $stable(status) &&
                                $stable(name_text) && $stable(file_size))
    else $error("Stalled result changed.");

  a_end_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_END |-> name_text == '0 && name_length == '0 &&
      ext_text == '0 && ext_length == '0 && file_size == '0 && first_cluster == '0)
    else $error("End result carries file fields.");

  a_name_length_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> name_length <= NAME_LEN_W'(NAME_BYTES))
    else $error("Name length out of range.");

  a_pready_high: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("Configuration port not ready.");

endmodule

bind fat_directory_entry_filter fdef_checker u_fdef_checker (.*);
